// File: design/range_add_range_min_tree_core_macros.svh
// Assertion macros shared by the checker of the range add, range minimum tree.
`ifndef RANGE_ADD_RANGE_MIN_TREE_CORE_MACROS_SVH
`define RANGE_ADD_RANGE_MIN_TREE_CORE_MACROS_SVH

// Same-cycle implication, clocked on clk_i and silent while reset is held.
`define RAMT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ramt: assertion failed");

// Next-cycle implication, clocked on clk_i and silent while reset is held.
`define RAMT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ramt: assertion failed");

`endif

// File: design/ramt_pkg.sv
// Types, constants and helper functions of the range add, range minimum tree.
package ramt_pkg;

  localparam int unsigned IdxW       = 10;
  localparam int unsigned CntW       = 11;
  localparam int unsigned NodeW      = 11;
  localparam int unsigned ValW       = 48;
  localparam int unsigned TreeLevels = 10;
  localparam int unsigned NodeCount  = 2048;

  typedef logic signed [ValW-1:0] val_t;
  typedef logic [NodeW-1:0]       node_t;
  typedef logic [CntW-1:0]        bound_t;

  // Operation codes of the command port.
  typedef enum logic [1:0] {
    OpLoad = 2'd0,
    OpAdd  = 2'd1,
    OpMin  = 2'd2
  } op_e;

  // Register indexes of the configuration port.
  localparam logic CfgElementCount = 1'b0;
  localparam logic CfgEmptyValue   = 1'b1;

  localparam bound_t CountReset = bound_t'(1024);
  localparam val_t   EmptyReset = val_t'(48'sd1000000000);

  // Sequencer states.
  typedef enum logic [3:0] {
    StClear,
    StIdle,
    StRead,
    StEval,
    StPd0,
    StPd1,
    StPd2,
    StPd3,
    StRet,
    StPu0,
    StPu1,
    StPu2
  } state_e;

  // Half-open leaf span [lo, hi) of a tree node.
  typedef struct packed {
    bound_t lo;
    bound_t hi;
  } span_t;

  // The level of a node is the position of its leading one; the span follows from it.
  function automatic span_t node_span(node_t nd);
    logic [3:0]            lvl;
    logic [NodeW+IdxW-1:0] wide;
    span_t                 sp;
    lvl = '0;
    for (int i = 0; i < NodeW; i++) begin
      if (nd[i]) begin
        lvl = 4'(i);
      end
    end
    wide  = {{IdxW{1'b0}}, nd} << (4'(TreeLevels) - lvl);
    sp.lo = {1'b0, wide[IdxW-1:0]};
    sp.hi = sp.lo + (bound_t'(1) << (4'(TreeLevels) - lvl));
    return sp;
  endfunction

  // Signed minimum of two values.
  function automatic val_t pick_min(val_t a, val_t b);
    return (a < b) ? a : b;
  endfunction

endpackage

// File: design/range_add_range_min_tree_core.sv
// Lazy segment tree with range add and range minimum over 48-bit signed values.
//
//  channel   | handshake                | payload
//  ----------+--------------------------+------------------------------------------
//  command   | start_i, busy_o          | op_i, index_lo_i, index_hi_i, value_i
//  result    | result_valid_o (strobe)  | min_value_o
//  config    | cfg_we_i                 | cfg_index_i, cfg_data_i
//
// After reset a clearing pass zeroes every entry of the pending-add memory; busy_o is high.
// Each visited node passes through the read, evaluate and return states, through StPd0 to
// StPd3 when a pending add is pushed to its children, and through StPu0 to StPu2 to
// recombine the children after a load or an add. A wrapped range of an add or query is
// walked in up to two parts, one after the other; each of the two node memories has a
// single read and a single write port. An empty query answers in the cycle after its beat
// without raising busy_o. A query result shows for one cycle.
module range_add_range_min_tree_core
  import ramt_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic [1:0]             op_i,
  input  logic [IdxW-1:0]        index_lo_i,
  input  logic [IdxW-1:0]        index_hi_i,
  input  logic signed [ValW-1:0] value_i,
  output logic                   result_valid_o,
  output logic signed [ValW-1:0] min_value_o,
  input  logic                   cfg_we_i,
  input  logic                   cfg_index_i,
  input  logic [ValW-1:0]        cfg_data_i
);

  // Node memories: subtree value including the node's own pending add, and that add.
  val_t val_mem  [NodeCount];
  val_t pend_mem [NodeCount];

  state_e state_q, state_d;
  node_t  node_q, node_d;
  op_e    op_q, op_d;
  val_t   value_q, value_d;
  bound_t cur_lo_q, cur_lo_d, cur_hi_q, cur_hi_d;
  bound_t nxt_lo_q, nxt_lo_d, nxt_hi_q, nxt_hi_d;
  logic   nxt_v_q, nxt_v_d;
  val_t   best_q, best_d;
  val_t   hold_q, hold_d;
  node_t  clr_q, clr_d;
  logic   result_valid_q, result_valid_d;
  val_t   min_value_q, min_value_d;
  bound_t element_count_q;
  val_t   empty_value_q;

  val_t   rd_val_q, rd_pend_q;
  node_t  rd_addr;
  logic   val_we, pend_we;
  node_t  val_waddr, pend_waddr;
  val_t   val_wdata, pend_wdata;

  logic   accept;
  logic   op_ok;
  bound_t cnt, lo_w, hi_w;
  bound_t a_lo, a_hi, b_lo, b_hi;
  logic   b_en, a_v, b_v;
  span_t  span;
  logic   no_ovl, full;
  node_t  left_n, right_n, parent_n;
  logic   is_root;

  assign accept = start_i && !busy_o;
  assign op_ok  = (op_i == OpLoad) || (op_i == OpAdd) || (op_i == OpMin);

  // Split the command range into at most two clipped half-open parts.
  always_comb begin
    cnt  = (element_count_q > CountReset) ? CountReset : element_count_q;
    lo_w = {1'b0, index_lo_i};
    hi_w = {1'b0, index_hi_i} + bound_t'(1);
    b_lo = lo_w;
    b_hi = cnt;
    b_en = 1'b0;
    if (op_i == OpLoad) begin
      a_lo = lo_w;
      a_hi = lo_w + bound_t'(1);
    end else if (index_lo_i <= index_hi_i) begin
      a_lo = lo_w;
      a_hi = hi_w;
    end else begin
      a_lo = '0;
      a_hi = hi_w;
      b_en = 1'b1;
    end
    if (a_lo > cnt) a_lo = cnt;
    if (a_hi > cnt) a_hi = cnt;
    if (b_lo > cnt) b_lo = cnt;
    a_v = a_lo < a_hi;
    b_v = b_en && (b_lo < b_hi);
  end

  // Geometry of the current node.
  assign span     = node_span(node_q);
  assign no_ovl   = (cur_hi_q <= span.lo) || (span.hi <= cur_lo_q);
  assign full     = (cur_lo_q <= span.lo) && (span.hi <= cur_hi_q);
  assign left_n   = {node_q[NodeW-2:0], 1'b0};
  assign right_n  = {node_q[NodeW-2:0], 1'b1};
  assign parent_n = {1'b0, node_q[NodeW-1:1]};
  assign is_root  = node_q == node_t'(1);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StClear: if (clr_q == node_t'(NodeCount - 1)) state_d = StIdle;
      StIdle: begin
        if (accept && op_ok && (a_v || b_v)) state_d = StRead;
      end
      StRead: state_d = StEval;
      StEval: begin
        priority if (no_ovl || full) state_d = StRet;
        else if (rd_pend_q != '0)    state_d = StPd0;
        else                         state_d = StRead;
      end
      StPd0: state_d = StPd1;
      StPd1: state_d = StPd2;
      StPd2: state_d = StPd3;
      StPd3: state_d = StRead;
      StRet: begin
        priority if (is_root) state_d = nxt_v_q ? StRead : StIdle;
        else if (!node_q[0])  state_d = StRead;
        else if (op_q == OpMin) state_d = StRet;
        else                  state_d = StPu0;
      end
      StPu0: state_d = StPu1;
      StPu1: state_d = StPu2;
      StPu2: state_d = StRet;
      default: state_d = StIdle;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    node_d         = node_q;
    op_d           = op_q;
    value_d        = value_q;
    cur_lo_d       = cur_lo_q;
    cur_hi_d       = cur_hi_q;
    nxt_lo_d       = nxt_lo_q;
    nxt_hi_d       = nxt_hi_q;
    nxt_v_d        = nxt_v_q;
    best_d         = best_q;
    hold_d         = hold_q;
    clr_d          = clr_q;
    result_valid_d = 1'b0;
    min_value_d    = min_value_q;
    rd_addr        = node_q;
    val_we         = 1'b0;
    pend_we        = 1'b0;
    val_waddr      = node_q;
    pend_waddr     = node_q;
    val_wdata      = rd_val_q;
    pend_wdata     = '0;
    unique case (state_q)
      StClear: begin
        pend_we    = 1'b1;
        pend_waddr = clr_q;
        clr_d      = clr_q + node_t'(1);
      end
      StIdle: begin
        if (accept && op_ok) begin
          op_d    = op_e'(op_i);
          value_d = value_i;
          best_d  = empty_value_q;
          node_d  = node_t'(1);
          if (a_v) begin
            cur_lo_d = a_lo;
            cur_hi_d = a_hi;
            nxt_lo_d = b_lo;
            nxt_hi_d = b_hi;
            nxt_v_d  = b_v;
          end else begin
            cur_lo_d = b_lo;
            cur_hi_d = b_hi;
            nxt_v_d  = 1'b0;
          end
          if (op_i == OpMin && !a_v && !b_v) begin
            result_valid_d = 1'b1;
            min_value_d    = empty_value_q;
          end
        end
      end
      StRead: ;
      StEval: begin
        if (full) begin
          unique case (op_q)
            OpLoad: begin
              val_we     = 1'b1;
              val_wdata  = value_q;
              pend_we    = 1'b1;
              pend_wdata = '0;
            end
            OpAdd: begin
              val_we     = 1'b1;
              val_wdata  = rd_val_q + value_q;
              pend_we    = 1'b1;
              pend_wdata = rd_pend_q + value_q;
            end
            OpMin: best_d = pick_min(best_q, rd_val_q);
            default: ;
          endcase
        end else if (!no_ovl) begin
          hold_d = rd_pend_q;
          if (rd_pend_q == '0) node_d = left_n;
        end
      end
      // Push the held add into both children, then clear it at the node.
      StPd0: rd_addr = left_n;
      StPd1: begin
        rd_addr    = right_n;
        val_we     = 1'b1;
        val_waddr  = left_n;
        val_wdata  = rd_val_q + hold_q;
        pend_we    = 1'b1;
        pend_waddr = left_n;
        pend_wdata = rd_pend_q + hold_q;
      end
      StPd2: begin
        val_we     = 1'b1;
        val_waddr  = right_n;
        val_wdata  = rd_val_q + hold_q;
        pend_we    = 1'b1;
        pend_waddr = right_n;
        pend_wdata = rd_pend_q + hold_q;
      end
      StPd3: begin
        pend_we    = 1'b1;
        pend_wdata = '0;
        node_d     = left_n;
      end
      StRet: begin
        priority if (is_root) begin
          if (nxt_v_q) begin
            cur_lo_d = nxt_lo_q;
            cur_hi_d = nxt_hi_q;
            nxt_v_d  = 1'b0;
            node_d   = node_t'(1);
          end else if (op_q == OpMin) begin
            result_valid_d = 1'b1;
            min_value_d    = best_q;
          end
        end else if (!node_q[0]) begin
          // Move on to the right sibling.
          node_d = node_q | node_t'(1);
        end else begin
          node_d = parent_n;
        end
      end
      // Recombine the two children into the node.
      StPu0: rd_addr = left_n;
      StPu1: begin
        rd_addr = right_n;
        hold_d  = rd_val_q;
      end
      StPu2: begin
        val_we    = 1'b1;
        val_wdata = pick_min(hold_q, rd_val_q);
      end
      default: ;
    endcase
  end

  // Node memories, one read and one write port each, registered read data.
  always_ff @(posedge clk_i) begin
    if (val_we) val_mem[val_waddr] <= val_wdata;
    rd_val_q <= val_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (pend_we) pend_mem[pend_waddr] <= pend_wdata;
    rd_pend_q <= pend_mem[rd_addr];
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StClear;
      clr_q          <= '0;
      nxt_v_q        <= 1'b0;
      result_valid_q <= 1'b0;
      element_count_q <= CountReset;
      empty_value_q  <= EmptyReset;
    end else begin
      state_q        <= state_d;
      clr_q          <= clr_d;
      nxt_v_q        <= nxt_v_d;
      result_valid_q <= result_valid_d;
      if (cfg_we_i) begin
        if (cfg_index_i == CfgElementCount) begin
          element_count_q <= cfg_data_i[CntW-1:0];
        end else begin
          empty_value_q <= cfg_data_i;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    node_q      <= node_d;
    op_q        <= op_d;
    value_q     <= value_d;
    cur_lo_q    <= cur_lo_d;
    cur_hi_q    <= cur_hi_d;
    nxt_lo_q    <= nxt_lo_d;
    nxt_hi_q    <= nxt_hi_d;
    best_q      <= best_d;
    hold_q      <= hold_d;
    min_value_q <= min_value_d;
  end

  assign busy_o         = state_q != StIdle;
  assign result_valid_o = result_valid_q;
  assign min_value_o    = min_value_q;

endmodule

// File: design/ramt_checker.sv
// Port-level checker of the range add, range minimum tree, bound to the top level.
`include "range_add_range_min_tree_core_macros.svh"

module ramt_checker
  import ramt_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic [1:0] op_i,
  input logic       result_valid_o
);

  // A result beat is shown only once the block has gone idle.
  `RAMT_ASSERT_NOW(a_result_when_idle, result_valid_o, !busy_o)

  // A result beat follows a command beat or a busy cycle.
  `RAMT_ASSERT_NOW(a_result_has_cause, result_valid_o, $past(busy_o) || $past(start_i))

  // An idle cycle without a command beat brings no result.
  `RAMT_ASSERT_NEXT(a_no_spurious_result, !busy_o && !start_i, !result_valid_o)

  // A load never answers.
  `RAMT_ASSERT_NEXT(a_load_silent, start_i && !busy_o && op_i == OpLoad, !result_valid_o)

endmodule

bind range_add_range_min_tree_core ramt_checker u_ramt_checker (.*);

// File: tb/tb.sv
// Testbench of the range add, range minimum tree: directed table, then random phases.
`timescale 1ns / 100ps

module tb;
  import ramt_pkg::*;

  localparam int unsigned Leaves    = 1024;
  localparam int unsigned Loaded    = 128;
  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned RandItems = 400;
  localparam logic [1:0]  OpUnused  = 2'd3;
  localparam logic [47:0] ValMin    = 48'h8000_0000_0000;
  localparam logic [47:0] ValMax    = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] EmptyDef  = 48'd1000000000;

  // One row of the directed table; a typed row carries its own expected minimum.
  typedef struct packed {
    logic [1:0]  op;
    logic [9:0]  lo;
    logic [9:0]  hi;
    logic [47:0] val;
    logic        typed;
    logic [47:0] want;
  } row_t;

  // The table runs with the element count set to the loaded elements, 0 to 127.
  localparam int unsigned NumRows = 25;
  localparam row_t Rows [NumRows] = '{
    '{OpLoad, 10'd5, 10'd0, -48'sd7, 1'b0, 48'd0},
    '{OpMin, 10'd5, 10'd5, 48'd0, 1'b1, -48'sd7},
    '{OpLoad, 10'd127, 10'd0, ValMax, 1'b0, 48'd0},
    '{OpMin, 10'd127, 10'd127, 48'd0, 1'b1, EmptyDef},
    '{OpLoad, 10'd0, 10'd0, ValMin, 1'b0, 48'd0},
    '{OpMin, 10'd0, 10'd0, 48'd0, 1'b1, ValMin},
    '{OpMin, 10'd0, 10'd1023, 48'd0, 1'b1, ValMin},
    '{OpAdd, 10'd0, 10'd0, -48'sd1, 1'b0, 48'd0},
    '{OpMin, 10'd0, 10'd0, 48'd0, 1'b1, EmptyDef},
    '{OpAdd, 10'd127, 10'd127, 48'd1, 1'b0, 48'd0},
    '{OpMin, 10'd127, 10'd127, 48'd0, 1'b1, ValMin},
    '{OpMin, 10'd100, 10'd3, 48'd0, 1'b0, 48'd0},
    '{OpAdd, 10'd120, 10'd2, 48'd5, 1'b0, 48'd0},
    '{OpMin, 10'd119, 10'd4, 48'd0, 1'b0, 48'd0},
    '{OpUnused, 10'd0, 10'd1023, 48'd0, 1'b0, 48'd0},
    '{OpMin, 10'd0, 10'd1023, 48'd0, 1'b0, 48'd0},
    '{OpAdd, 10'd0, 10'd1023, ValMax, 1'b0, 48'd0},
    '{OpLoad, 10'd127, 10'd0, 48'd3, 1'b0, 48'd0},
    '{OpMin, 10'd127, 10'd127, 48'd0, 1'b1, 48'd3},
    '{OpMin, 10'd64, 10'd63, 48'd0, 1'b0, 48'd0},
    '{OpAdd, 10'd30, 10'd70, 48'd123, 1'b0, 48'd0},
    '{OpMin, 10'd30, 10'd70, 48'd0, 1'b0, 48'd0},
    '{OpMin, 10'd71, 10'd29, 48'd0, 1'b0, 48'd0},
    '{OpLoad, 10'd1023, 10'd0, 48'd9, 1'b0, 48'd0},
    '{OpMin, 10'd1023, 10'd1023, 48'd0, 1'b1, EmptyDef}
  };

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   start_i = 1'b0;
  logic                   busy_o;
  logic [1:0]             op_i = '0;
  logic [IdxW-1:0]        index_lo_i = '0;
  logic [IdxW-1:0]        index_hi_i = '0;
  logic signed [ValW-1:0] value_i = '0;
  logic                   result_valid_o;
  logic signed [ValW-1:0] min_value_o;
  logic                   cfg_we_i = 1'b0;
  logic                   cfg_index_i = 1'b0;
  logic [ValW-1:0]        cfg_data_i = '0;

  // Shadow tree, shadow registers and the store of minima still to arrive.
  logic [47:0] shadow_min  [2048];
  logic [47:0] shadow_pend [2048];
  logic [10:0] shadow_count;
  logic [47:0] shadow_empty;
  logic [47:0] pending_minima [$];
  int          fail_count = 0;
  int          beats_sent;
  int          minima_seen = 0;
  int          idle_cycles = 0;

  always #2 clk_i = ~clk_i;

  range_add_range_min_tree_core dut (.*);

  function automatic logic [47:0] lesser(logic [47:0] a, logic [47:0] b);
    return ($signed(a) < $signed(b)) ? a : b;
  endfunction

  function automatic logic [47:0] node_total(int nd);
    return shadow_min[nd] + shadow_pend[nd];
  endfunction

  // Walks the shadow tree depth first over [l, r) with an explicit stack.
  function automatic logic [47:0] tree_walk(op_e kind, int l, int r, logic [47:0] v,
                                            logic [47:0] best);
    int nd_s [64];
    int lb_s [64];
    int rb_s [64];
    bit up_s [64];
    int sp;
    int nd;
    int lb;
    int rb;
    int mid;
    sp = 1;
    nd_s[0] = 1;
    lb_s[0] = 0;
    rb_s[0] = Leaves;
    up_s[0] = 1'b0;
    while (sp > 0) begin
      sp--;
      nd = nd_s[sp];
      lb = lb_s[sp];
      rb = rb_s[sp];
      if (up_s[sp]) begin
        shadow_min[nd] = lesser(node_total(2 * nd), node_total(2 * nd + 1));
      end else if (!(r <= lb || rb <= l)) begin
        if (l <= lb && rb <= r) begin
          case (kind)
            OpLoad: begin
              shadow_min[nd] = v;
              shadow_pend[nd] = '0;
            end
            OpAdd: begin
              shadow_pend[nd] = shadow_pend[nd] + v;
            end
            default: begin
              best = lesser(best, node_total(nd));
            end
          endcase
        end else begin
          // Hand the pending add down before visiting the children.
          if (shadow_pend[nd] != '0) begin
            shadow_pend[2 * nd] = shadow_pend[2 * nd] + shadow_pend[nd];
            shadow_pend[2 * nd + 1] = shadow_pend[2 * nd + 1] + shadow_pend[nd];
            shadow_min[nd] = node_total(nd);
            shadow_pend[nd] = '0;
          end
          mid = (lb + rb) / 2;
          if (kind != OpMin) begin
            nd_s[sp] = nd; up_s[sp] = 1'b1; sp++;
          end
          nd_s[sp] = 2 * nd + 1; lb_s[sp] = mid; rb_s[sp] = rb; up_s[sp] = 1'b0; sp++;
          nd_s[sp] = 2 * nd; lb_s[sp] = lb; rb_s[sp] = mid; up_s[sp] = 1'b0; sp++;
        end
      end
    end
    return best;
  endfunction

  // Applies one half-open part of a range, cut at the element count.
  function automatic logic [47:0] range_part(op_e kind, int l, int r, int cnt, logic [47:0] v,
                                             logic [47:0] best);
    if (l > cnt) l = cnt;
    if (r > cnt) r = cnt;
    if (l >= r) return best;
    return tree_walk(kind, l, r, v, best);
  endfunction

  // Updates the shadow tree for one accepted beat; returns 1 when a minimum is due.
  function automatic bit predict_minimum(logic [1:0] op, int lo, int hi, logic [47:0] v,
                                         output logic [47:0] minimum);
    int cnt;
    cnt = (shadow_count > Leaves) ? Leaves : int'(shadow_count);
    minimum = shadow_empty;
    if (op == OpLoad) begin
      if (lo < cnt) void'(tree_walk(OpLoad, lo, lo + 1, v, minimum));
      return 1'b0;
    end
    if (op == OpUnused) return 1'b0;
    if (lo <= hi) begin
      minimum = range_part(op_e'(op), lo, hi + 1, cnt, v, minimum);
    end else begin
      minimum = range_part(op_e'(op), 0, hi + 1, cnt, v, minimum);
      minimum = range_part(op_e'(op), lo, cnt, cnt, v, minimum);
    end
    return op == OpMin;
  endfunction

  // Sends one command beat and waits for it to be taken.
  task automatic send_beat(logic [1:0] op, int lo, int hi, logic [47:0] v,
                           bit typed, logic [47:0] want);
    logic [47:0] minimum;
    start_i    <= 1'b1;
    op_i       <= op;
    index_lo_i <= IdxW'(lo);
    index_hi_i <= IdxW'(hi);
    value_i    <= v;
    do @(posedge clk_i); while (busy_o);
    if (predict_minimum(op, lo, hi, v, minimum)) begin
      pending_minima = {pending_minima, (typed ? want : minimum)};
    end
    beats_sent++;
  endtask

  // Random gap on the command side: mostly none, sometimes short, rarely long.
  task automatic sender_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick >= 60) begin
      start_i <= 1'b0;
      repeat ((pick < 92) ? $urandom_range(1, 3) : $urandom_range(20, 200)) @(posedge clk_i);
    end
  endtask

  // Waits until every minimum has come and the block has gone idle.
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_minima.size() != 0 || busy_o) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [47:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgElementCount) shadow_count = data[10:0];
    else shadow_empty = data;
  endtask

  function automatic logic [47:0] rand_value();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) return 48'($signed($urandom_range(0, 2000)) - 1000);
    if (pick < 7) return 48'({$urandom(), $urandom()});
    case ($urandom_range(0, 3))
      0: return ValMin;
      1: return ValMax;
      2: return '1;
      default: return '0;
    endcase
  endfunction

  function automatic int rand_index(int cnt);
    if ($urandom_range(0, 1) == 0) return $urandom_range(0, Leaves - 1);
    return $urandom_range(0, (cnt + 2 > Leaves - 1) ? Leaves - 1 : cnt + 2);
  endfunction

  // Minimum strobe check against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      minima_seen++;
      if (pending_minima.size() == 0) begin
        $error("min_value: unexpected beat, actual %0d", min_value_o);
        fail_count++;
      end else begin
        if (min_value_o !== pending_minima[0]) begin
          $error("min_value: expected %0d, actual %0d", $signed(pending_minima[0]), min_value_o);
          fail_count++;
        end
        void'(pending_minima.pop_front());
      end
    end
  end

  // Watchdog on cycles in which nothing moves.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || result_valid_o || cfg_we_i) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [10:0] counts [6];
    logic [47:0] empties [6];
    int          op_pick;
    int          per_phase;
    int          lo;
    int          hi;
    logic [1:0]  op;
    beats_sent = 0;
    shadow_count = CountReset;
    shadow_empty = EmptyReset;
    for (int i = 0; i < 2048; i++) begin
      shadow_min[i] = '0;
      shadow_pend[i] = '0;
    end
    counts  = '{11'd0, 11'd1, 11'd60, 11'd128, 11'd2047, 11'd1025};
    empties = '{ValMin, ValMax, 48'({$urandom(), $urandom()}), 48'd0, EmptyDef, ValMax};

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The low elements get a value before any add or query; ranges stay within them.
    for (int i = 0; i < Loaded; i++) begin
      send_beat(OpLoad, i, $urandom_range(0, Leaves - 1), rand_value(), 1'b0, '0);
      if ($urandom_range(0, 9) == 0) sender_gap();
    end
    drain();
    write_reg(CfgElementCount, 48'(Loaded));

    // Directed table: extremes, wrapped ranges, overflow, reload, indices beyond the count
    // and the unused code.
    for (int i = 0; i < NumRows; i++) begin
      send_beat(Rows[i].op, Rows[i].lo, Rows[i].hi, Rows[i].val, Rows[i].typed, Rows[i].want);
      sender_gap();
    end

    // Random phases, each under its own register setting.
    per_phase = RandItems / 6;
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      write_reg(CfgElementCount, 48'(counts[ph]));
      write_reg(CfgEmptyValue, empties[ph]);
      for (int n = 0; n < per_phase; n++) begin
        op_pick = $urandom_range(0, 99);
        op = (op_pick < 10) ? OpLoad : (op_pick < 50) ? OpAdd : (op_pick < 95) ? OpMin : OpUnused;
        // With a count above the loaded elements, ranges are kept plain and inside them.
        if (op != OpLoad && shadow_count > 11'(Loaded)) begin
          lo = $urandom_range(0, Loaded - 1);
          hi = $urandom_range(lo, Loaded - 1);
        end else begin
          lo = rand_index(int'(shadow_count));
          hi = rand_index(int'(shadow_count));
        end
        send_beat(op, lo, hi, rand_value(), 1'b0, '0);
        // Once per phase the sender holds off until all minima are back.
        if (n == per_phase / 2) begin
          drain();
        end else if (ph % 2 == 0 || n > per_phase / 3) begin
          sender_gap();
        end
      end
    end

    drain();
    repeat (50) @(posedge clk_i);
    $display("Covered %0d command beats and %0d minima over six register settings.",
             beats_sent, minima_seen);
    if (fail_count == 0 && pending_minima.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+design
design/ramt_pkg.sv
design/range_add_range_min_tree_core.sv
design/ramt_checker.sv
tb/tb.sv
